@@ rtl/core/dvft_pkg.sv @@
`default_nettype none

package dvft_pkg;

    // Table geometry and field widths
    localparam int TABLE_DEPTH = 64;
    localparam int VALUE_W     = 32;
    localparam int COUNT_W     = 32;

    typedef logic signed [VALUE_W-1:0] t_value;
    typedef logic        [COUNT_W-1:0] t_count;

    // Item travelling down the chain, one cell per cycle
    typedef struct packed {
        logic   live;   // still to be counted
        logic   eos;    // end-of-stream marker
        t_value value;
    } t_item;

    // Contents of one cell, shifted towards the head during a dump
    typedef struct packed {
        logic   valid;
        t_value value;
        t_count count;
    } t_entry;

    localparam t_count COUNT_MAX   = '1;
    localparam t_count COUNT_ONE   = t_count'(1);
    localparam t_entry ENTRY_EMPTY = '{valid: 1'b0, value: '0, count: '0};

endpackage

`default_nettype wire

@@ rtl/core/dvft_if.sv @@
`default_nettype none

// Input channel: one value per transaction
interface dvft_in_if;
    logic                  valid;
    logic                  ready;
    dvft_pkg::t_value      value;
    logic                  end_of_stream;

    modport source (output valid, output value, output end_of_stream, input ready);
    modport sink   (input valid, input value, input end_of_stream, output ready);
endinterface

// Output channel: one table entry per transaction
interface dvft_out_if;
    logic                  valid;
    logic                  ready;
    dvft_pkg::t_value      distinct_value;
    dvft_pkg::t_count      occurrences;
    logic                  last_entry;
    logic                  overflowed;

    modport source (output valid, output distinct_value, output occurrences,
                    output last_entry, output overflowed, input ready);
    modport sink   (input valid, input distinct_value, input occurrences,
                    input last_entry, input overflowed, output ready);
endinterface

`default_nettype wire

@@ rtl/core/dvft_cell.sv @@
`default_nettype none

module dvft_cell (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire dvft_pkg::t_item  i_item,
    output dvft_pkg::t_item       o_item,
    input  wire logic            i_shift,
    input  wire dvft_pkg::t_entry i_next_entry,
    output dvft_pkg::t_entry      o_entry
);
    import dvft_pkg::*;

    logic   r_valid;
    t_value r_value;
    t_count r_count;

    logic   r_live;
    logic   r_eos;
    t_value r_item_value;

    logic   w_match;
    logic   w_claim;

    // Compare the passing item with the stored value; an empty cell takes a new value,
    // cells fill from the head so the first empty one met is the next free slot
    assign w_match = i_item.live && r_valid && (r_value == i_item.value);
    assign w_claim = i_item.live && !r_valid;

    // Hand the item to the neighbour, dropping its live flag once counted
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live <= 1'b0;
            r_eos  <= 1'b0;
        end else begin
            r_live <= i_item.live && !w_match && !w_claim;
            r_eos  <= i_item.eos;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item_value <= i_item.value;
    end

    // Hold, count, claim, or take the neighbour's entry during a dump
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_shift) begin
            r_valid <= i_next_entry.valid;
        end else if (w_claim) begin
            r_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_value <= i_next_entry.value;
            r_count <= i_next_entry.count;
        end else if (w_claim) begin
            r_value <= i_item.value;
            r_count <= COUNT_ONE;
        end else if (w_match && (r_count != COUNT_MAX)) begin
            r_count <= r_count + COUNT_ONE;
        end
    end

    assign o_item  = '{live: r_live, eos: r_eos, value: r_item_value};
    assign o_entry = '{valid: r_valid, value: r_value, count: r_count};

endmodule

`default_nettype wire

@@ rtl/core/distinct_value_frequency_table.sv @@
// Timing: an item walks the chain of TABLE_DEPTH cells, one cell per cycle; a dump starts once the
// end-of-stream item leaves the chain tail, and each entry is loaded into the output register.
// Throughput: one value per cycle while counting; during a dump one entry per cycle while the
// result channel is not stalled; input is held off from the end-of-stream transaction until the
// last entry is loaded out. Reset: clears the cell valid bits, the overflow flag and the handshake
// state; stored values and counts are not cleared and are never read before they are written.
`default_nettype none

module distinct_value_frequency_table (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    dvft_in_if.sink    i_sample,
    dvft_out_if.source o_result
);
    import dvft_pkg::*;

    t_item  w_item  [TABLE_DEPTH+1];
    t_entry w_entry [TABLE_DEPTH];
    t_entry w_next  [TABLE_DEPTH];

    logic   r_busy;
    logic   r_dumping;
    logic   r_overflow;

    logic   r_out_valid;
    t_value r_out_value;
    t_count r_out_count;
    logic   r_out_last;
    logic   r_out_ovf;

    logic   w_accept;
    logic   w_load;
    logic   w_last;
    t_item  w_tail;

    assign w_accept = i_sample.valid && !r_busy;
    assign w_load   = r_dumping && (!r_out_valid || o_result.ready);
    assign w_last   = !w_next[0].valid;
    assign w_tail   = w_item[TABLE_DEPTH];

    // Feed the head of the chain
    assign w_item[0] = '{live:  w_accept,
                         eos:   w_accept && i_sample.end_of_stream,
                         value: i_sample.value};

    // Row of cells; entries move one place towards the head on each dump step
    for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
        if (k + 1 < TABLE_DEPTH) begin : g_mid
            assign w_next[k] = w_entry[k+1];
        end else begin : g_end
            assign w_next[k] = ENTRY_EMPTY;
        end

        dvft_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_item       (w_item[k]),
            .o_item       (w_item[k+1]),
            .i_shift      (w_load),
            .i_next_entry (w_next[k]),
            .o_entry      (w_entry[k])
        );
    end

    // Control: hold off input until the dump is done; track overflow at the chain tail
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_dumping  <= 1'b0;
            r_overflow <= 1'b0;
        end else begin
            if (w_accept && i_sample.end_of_stream) begin
                r_busy <= 1'b1;
            end
            if (w_tail.live) begin
                r_overflow <= 1'b1;
            end
            if (w_tail.eos) begin
                r_dumping <= 1'b1;
            end
            if (w_load && w_last) begin
                r_busy     <= 1'b0;
                r_dumping  <= 1'b0;
                r_overflow <= 1'b0;
            end
        end
    end

    // Output register: advance when empty or taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_value <= w_entry[0].value;
            r_out_count <= w_entry[0].count;
            r_out_last  <= w_last;
            r_out_ovf   <= r_overflow;
        end
    end

    assign i_sample.ready          = !r_busy;
    assign o_result.valid          = r_out_valid;
    assign o_result.distinct_value = r_out_value;
    assign o_result.occurrences    = r_out_count;
    assign o_result.last_entry     = r_out_last;
    assign o_result.overflowed     = r_out_ovf;

endmodule

`default_nettype wire

@@ rtl/core/dvft_checker.sv @@
`default_nettype none

module dvft_checker (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_in_valid,
    input wire logic              i_in_ready,
    input wire logic              i_in_eos,
    input wire logic              i_out_valid,
    input wire logic              i_out_ready,
    input wire dvft_pkg::t_value  i_out_value,
    input wire dvft_pkg::t_count  i_out_count,
    input wire logic              i_out_last
);
    import dvft_pkg::*;

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_value) && $stable(i_out_count) && $stable(i_out_last))
        else $error("result changed while stalled");

    // An end-of-stream transaction closes the input
    a_eos_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_eos |=> !i_in_ready)
        else $error("input open after end of stream");

    // No input while a dump still has entries to come
    a_dump_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_last |-> !i_in_ready)
        else $error("input open during dump");

    // Every reported entry was seen at least once
    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_count != '0))
        else $error("zero count reported");

endmodule

bind distinct_value_frequency_table dvft_checker u_dvft_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_sample.valid),
    .i_in_ready  (i_sample.ready),
    .i_in_eos    (i_sample.end_of_stream),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_out_value (o_result.distinct_value),
    .i_out_count (o_result.occurrences),
    .i_out_last  (o_result.last_entry)
);

`default_nettype wire

@@ tb/sv/dvft_result_checker.sv @@
`timescale 1ns / 100ps

module dvft_result_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    dvft_in_if   i_sample_mon,
    dvft_out_if  i_result_mon,
    output int   o_fail_count,
    output int   o_pending
);
    import dvft_pkg::*;

    // One expected dump entry
    typedef struct packed {
        t_value value;
        t_count count;
        logic   last;
        logic   ovf;
    } t_tally_entry;

    t_value       tally_values [TABLE_DEPTH];
    t_count       tally_counts [TABLE_DEPTH];
    int           tally_used     = 0;
    logic         tally_overflow = 1'b0;
    t_tally_entry dump_queue [$];
    int           fail_count     = 0;

    always @(posedge i_clk) begin : tally_check
        t_tally_entry want;
        int           k;
        logic         hit;

        if (!i_rst_n) begin
            tally_used     = 0;
            tally_overflow = 1'b0;
            dump_queue.delete();
        end else begin
            // Compare each result transaction with the oldest expected entry
            if (i_result_mon.valid && i_result_mon.ready) begin
                if (dump_queue.size() == 0) begin
                    $error("distinct_value: expected no transaction, got 0x%h",
                           i_result_mon.distinct_value);
                    fail_count++;
                end else begin
                    want = dump_queue.pop_front();
                    if (i_result_mon.distinct_value !== want.value) begin
                        $error("distinct_value: expected 0x%h, got 0x%h",
                               want.value, i_result_mon.distinct_value);
                        fail_count++;
                    end
                    if (i_result_mon.occurrences !== want.count) begin
                        $error("occurrences: expected %0d, got %0d",
                               want.count, i_result_mon.occurrences);
                        fail_count++;
                    end
                    if (i_result_mon.last_entry !== want.last) begin
                        $error("last_entry: expected %0b, got %0b",
                               want.last, i_result_mon.last_entry);
                        fail_count++;
                    end
                    if (i_result_mon.overflowed !== want.ovf) begin
                        $error("overflowed: expected %0b, got %0b",
                               want.ovf, i_result_mon.overflowed);
                        fail_count++;
                    end
                end
            end

            // Tally each accepted sample: bump on a hit, append on a miss, else flag overflow
            if (i_sample_mon.valid && i_sample_mon.ready) begin
                hit = 1'b0;
                for (k = 0; k < tally_used; k++) begin
                    if (!hit && tally_values[k] == i_sample_mon.value) begin
                        hit = 1'b1;
                        if (tally_counts[k] != COUNT_MAX) begin
                            tally_counts[k] = tally_counts[k] + COUNT_ONE;
                        end
                    end
                end
                if (!hit) begin
                    if (tally_used < TABLE_DEPTH) begin
                        tally_values[tally_used] = i_sample_mon.value;
                        tally_counts[tally_used] = COUNT_ONE;
                        tally_used++;
                    end else begin
                        tally_overflow = 1'b1;
                    end
                end

                // Dump the table in order of first appearance, then clear it
                if (i_sample_mon.end_of_stream) begin
                    for (k = 0; k < tally_used; k++) begin
                        dump_queue.push_back('{value: tally_values[k],
                                               count: tally_counts[k],
                                               last:  logic'(k == tally_used - 1),
                                               ovf:   tally_overflow});
                    end
                    tally_used     = 0;
                    tally_overflow = 1'b0;
                end
            end
        end

        o_fail_count <= fail_count;
        o_pending    <= dump_queue.size();
    end

endmodule

@@ tb/sv/distinct_value_frequency_table_tb.sv @@
`timescale 1ns / 100ps

module distinct_value_frequency_table_tb;
    import dvft_pkg::*;

    typedef enum int {
        PH_FLOW,
        PH_SRC_IDLE,
        PH_SNK_STALL,
        PH_BOTH
    } t_idle_phase;

    localparam int RANDOM_ITEMS = 420;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int TAIL_CYCLES  = 2 * TABLE_DEPTH + 8;

    // Percent of cycles idle on each side, per phase
    localparam int GAP_PCT   [4] = '{0, 63, 0, 16};
    localparam int STALL_PCT [4] = '{0, 0, 63, 16};

    logic        i_clk;
    logic        i_rst_n;
    int          fail_count;
    int          pending;
    int          cycle_count = 0;
    int          sent_items  = 0;
    t_idle_phase idle_phase  = PH_FLOW;

    dvft_in_if  sample_ch ();
    dvft_out_if result_ch ();

    distinct_value_frequency_table u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (sample_ch),
        .o_result (result_ch)
    );

    dvft_result_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_sample_mon (sample_ch),
        .i_result_mon (result_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Free-running clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Stall the result channel at random according to the phase
    initial begin
        result_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            result_ch.ready <= ($urandom_range(0, 99) >= STALL_PCT[idle_phase]);
        end
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("distinct_value_frequency_table_tb NOT OK");
            $finish;
        end
    end

    // Offer one sample after a random idle stretch and hold it until accepted
    task automatic send_item(input t_value value, input logic eos);
        while ($urandom_range(0, 99) < GAP_PCT[idle_phase]) begin
            sample_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        sample_ch.valid         <= 1'b1;
        sample_ch.value         <= value;
        sample_ch.end_of_stream <= eos;
        do @(posedge i_clk); while (!sample_ch.ready);
        sent_items++;
    endtask

    initial begin : stimulus
        t_value      pool [4];
        t_value      long_seen [$];
        logic [6:0]  tag_mask;
        logic [31:0] raw;
        logic        ended;
        int          directed_items;
        int          stream_idx;
        int          n_distinct;
        int          n_new;
        int          len;
        int          k;

        sample_ch.valid         <= 1'b0;
        sample_ch.value         <= '0;
        sample_ch.end_of_stream <= 1'b0;
        i_rst_n                 <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Single-entry dump of the largest value
        send_item(32'sh7FFF_FFFF, 1'b1);
        // Extremes with repeats, end mark on a hit
        send_item(32'sh8000_0000, 1'b0);
        send_item(32'sh8000_0000, 1'b0);
        send_item(32'sh0000_0000, 1'b0);
        send_item(32'shFFFF_FFFF, 1'b0);
        send_item(32'sh0000_0001, 1'b0);
        send_item(32'shFFFF_FFFF, 1'b0);
        send_item(32'sh8000_0000, 1'b1);
        // Alternating bit patterns, end mark on a hit of the first entry
        send_item(32'sh5555_5555, 1'b0);
        send_item(32'shAAAA_AAAA, 1'b0);
        send_item(32'sh5555_5555, 1'b1);
        // Single-entry dump of zero
        send_item(32'sh0000_0000, 1'b1);
        directed_items = sent_items;

        stream_idx = 0;
        while (sent_items < directed_items + RANDOM_ITEMS) begin
            idle_phase <= t_idle_phase'(stream_idx % 4);
            if (stream_idx < 2 || $urandom_range(0, 11) == 0) begin
                // Long stream: exactly full first, then past full, then around full
                if (stream_idx == 0) begin
                    n_distinct = TABLE_DEPTH;
                end else if (stream_idx == 1) begin
                    n_distinct = $urandom_range(TABLE_DEPTH + 2, TABLE_DEPTH + 8);
                end else begin
                    n_distinct = $urandom_range(TABLE_DEPTH - 4, TABLE_DEPTH + 6);
                end
                // Tag the top bits so that every new value is distinct
                tag_mask = 7'($urandom);
                long_seen.delete();
                n_new = 0;
                ended = 1'b0;
                while (!ended) begin
                    if (n_new < n_distinct &&
                        (long_seen.size() == 0 || $urandom_range(0, 3) != 0)) begin
                        raw = {7'(n_new) ^ tag_mask, 25'($urandom)};
                        long_seen.push_back(raw);
                        n_new++;
                        ended = (n_new == n_distinct) && ($urandom_range(0, 1) == 1);
                    end else begin
                        raw   = long_seen[$urandom_range(0, long_seen.size() - 1)];
                        ended = (n_new == n_distinct);
                    end
                    send_item(raw, ended);
                end
            end else begin
                // Short stream over a small pool: many hits, the odd fresh value
                for (k = 0; k < 4; k++) begin
                    case ($urandom_range(0, 3))
                        0: pool[k] = $urandom_range(0, 6) - 3;
                        1: pool[k] = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
                        default: pool[k] = $urandom;
                    endcase
                end
                len = $urandom_range(1, 12);
                for (k = 0; k < len; k++) begin
                    raw = ($urandom_range(0, 7) == 0) ? $urandom : pool[$urandom_range(0, 3)];
                    send_item(raw, k == len - 1);
                end
            end
            stream_idx++;
        end
        sample_ch.valid <= 1'b0;

        // Drain the outstanding dumps, then watch for stray transactions
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("distinct_value_frequency_table_tb OK");
        end else begin
            $display("distinct_value_frequency_table_tb NOT OK");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/dvft_pkg.sv
rtl/core/dvft_if.sv
rtl/core/dvft_cell.sv
rtl/core/distinct_value_frequency_table.sv
rtl/core/dvft_checker.sv
tb/sv/dvft_result_checker.sv
tb/sv/distinct_value_frequency_table_tb.sv
